// ===== rtl/fppc_pkg.sv =====
package fppc_pkg;

  localparam int STEP_W = 24;   // step counter width
  localparam int POS_W  = 24;   // fused position, goal and error width
  localparam int GAIN_W = 24;
  localparam int DIST_W = 26;
  localparam int US_W   = 30;   // ultrasonic distance, Q14.16 mm
  localparam int SMM_W  = 38;   // step count converted to Q22.16 mm
  localparam int CMP_W  = 40;
  localparam int MA_W   = 32;   // shared multiplier operand A (signed)
  localparam int MB_W   = 25;   // shared multiplier operand B (signed)
  localparam int PR_W   = MA_W + MB_W;
  localparam int ACC_W  = 52;
  localparam int INT_W  = 25;   // integral, clamped to the 24-bit limit on each update
  localparam int IW_W   = 50;
  localparam int SUM_W  = 46;

  localparam logic [2:0] OP_STEP  = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_HOME  = 3'd4;

  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_ILIM   = 3'd3;
  localparam logic [2:0] REG_WINDOW = 3'd4;
  localparam logic [2:0] REG_NEAR   = 3'd5;
  localparam logic [2:0] REG_FAR    = 3'd6;
  localparam logic [2:0] REG_CAP    = 3'd7;

  localparam logic signed [MB_W-1:0] ECHO_A_GAIN = 25'sd2248;
  localparam logic signed [MB_W-1:0] ECHO_B_GAIN = 25'sd2202;
  localparam logic signed [MB_W-1:0] STEP_MM     = 25'sd2123;
  localparam logic signed [MB_W-1:0] MM_STEP     = 25'sd2022716;
  localparam logic signed [PR_W:0]   ECHO_OFS    = -58'sd127913;
  localparam logic signed [SMM_W-1:0] MM_ORIGIN  = 38'sd65536;
  localparam logic signed [MA_W-1:0] ORIGIN_A    = 32'sd65536;
  localparam logic signed [MA_W-1:0] NEAR_A      = 32'sd917504;  // 15 mm minus origin
  localparam logic signed [POS_W:0]  JUMP_LIMIT  = 25'sd15401;   // 500 mm minus origin, in steps

  typedef struct packed {
    logic step_ok;
    logic us_ok;
    logic move;
    logic calib;
    logic enable;
  } flags_t;

endpackage

// ===== rtl/fused_position_pid_controller_core.sv =====
// Channel   | Dir | Handshake               | Payload
// s_axis    | in  | tvalid/tready           | tuser: operation; tdata: echo_a, echo_b, target
// m_axis    | out | tvalid/tready           | tdata: period, direction, enable, position, flags
// cfg       | in  | cfg_we_i, no wait       | cfg_index_i selects register, cfg_data_i value
// Step edge, start, stop and homed requests pass through the execute state to the final
// state, which loads the result into the output register.
// A control tick walks the sequencer through the two echo products, the step count and two
// mm-to-step products, fusion, error, the P, D and I products, integral, sum, period and the
// final state; one shared 32x25 multiplier serves all eight products.
// The input is ready only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer holds in its final state while that is full and stalled.
// Reset is asynchronous and active low; it loads the default gains and limits.
module fused_position_pid_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // echo_a[15:0], echo_b[31:16], target_position[55:32]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // step_period[7:0], move_forward[8], step_enable[9],
                                      // position_steps[33:10], using_step_count[34],
                                      // movement_active[35], calibrating[36], zeros[39:37]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [fppc_pkg::DIST_W-1:0] cfg_data_i
);
  import fppc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_EA, ST_EB, ST_CNT, ST_MS1, ST_MS2, ST_FUSE,
    ST_ERR, ST_P, ST_D, ST_I, ST_INT, ST_SUM, ST_FIN, ST_DONE
  } state_e;

  state_e state_q;

  logic [GAIN_W-1:0] kp_q, ki_q, kd_q, ilim_q;
  logic [DIST_W-1:0] window_q, near_q, far_q;
  logic [7:0]        cap_q;

  logic [2:0]               op_q;
  logic [15:0]              echo_a_q, echo_b_q;
  logic signed [POS_W-1:0]  target_q;

  logic [STEP_W-1:0]        count_q;
  logic signed [POS_W-1:0]  fused_q, goal_q, prev_q, e_q;
  logic signed [POS_W:0]    d_q;
  logic signed [INT_W-1:0]  isum_q;
  logic                     level_q, dir_q;
  flags_t                   fl_q;
  logic [7:0]               period_q;

  logic signed [PR_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [US_W-1:0]   us_q;
  logic signed [SMM_W-1:0]  smm_q;
  logic signed [POS_W-1:0]  ms_us_q;
  logic signed [SUM_W-1:0]  s_q;

  // Shared multiplier operand selection.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_EA:  begin mul_a = MA_W'({1'b0, echo_a_q}); mul_b = ECHO_A_GAIN; end
      ST_EB:  begin mul_a = MA_W'({1'b0, echo_b_q}); mul_b = ECHO_B_GAIN; end
      ST_CNT: begin mul_a = MA_W'($signed(count_q)); mul_b = STEP_MM; end
      ST_MS1: begin mul_a = MA_W'(us_q) - ORIGIN_A;  mul_b = MM_STEP; end
      ST_MS2: begin mul_a = MA_W'(us_q) + NEAR_A;    mul_b = MM_STEP; end
      ST_P:   begin mul_a = MA_W'(e_q); mul_b = $signed({1'b0, kp_q}); end
      ST_D:   begin mul_a = MA_W'(d_q); mul_b = $signed({1'b0, kd_q}); end
      ST_I:   begin mul_a = MA_W'(e_q); mul_b = $signed({1'b0, ki_q}); end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  // Fusion terms.
  logic signed [CMP_W-1:0] smm_x, us_x, win_x;
  logic signed [POS_W-1:0] cnt_s, ms_near;
  logic                    inwin;

  assign smm_x   = CMP_W'(smm_q);
  assign us_x    = CMP_W'(us_q);
  assign win_x   = $signed(CMP_W'(window_q));
  assign inwin   = (smm_x >= us_x - win_x) && (smm_x <= us_x + win_x);
  assign cnt_s   = $signed(count_q);
  assign ms_near = prod_q[32 +: POS_W];

  // Error with saturation and jump rejection.
  logic signed [POS_W:0]   diff, e0x, d0;
  logic signed [POS_W-1:0] e0;
  logic                    reject;

  always_comb begin
    diff = {goal_q[POS_W-1], goal_q} - {fused_q[POS_W-1], fused_q};
    if (diff > $signed({2'b00, {(POS_W-1){1'b1}}}))
      e0 = {1'b0, {(POS_W-1){1'b1}}};
    else if (diff < $signed({2'b11, {(POS_W-1){1'b0}}}))
      e0 = {1'b1, {(POS_W-1){1'b0}}};
    else
      e0 = diff[POS_W-1:0];
    e0x    = {e0[POS_W-1], e0};
    d0     = e0x - {prev_q[POS_W-1], prev_q};
    reject = ((d0 > JUMP_LIMIT) || (d0 < -JUMP_LIMIT)) && !fl_q.calib;
  end

  // Integral update and clamp.
  logic signed [IW_W-1:0] inew, ilim_x;
  logic signed [INT_W-1:0] iclamp;

  always_comb begin
    ilim_x = $signed(IW_W'(ilim_q));
    inew   = IW_W'(isum_q) + IW_W'($signed(prod_q[PR_W-1:8]));
    if (inew > ilim_x)       iclamp = INT_W'(ilim_x);
    else if (inew < -ilim_x) iclamp = INT_W'(-ilim_x);
    else                     iclamp = INT_W'(inew);
  end

  // Drive magnitude to step period.
  logic [SUM_W-1:0] s_abs;
  logic [7:0]       mag;
  logic [8:0]       per;

  always_comb begin
    s_abs = s_q[SUM_W-1] ? SUM_W'(-s_q) : SUM_W'(s_q);
    mag   = (s_abs[SUM_W-1:16] > (SUM_W-16)'(255)) ? 8'd255 : s_abs[23:16];
    per   = 9'd256 - {1'b0, mag};
    if (fl_q.calib && per >= {1'b0, cap_q}) per = {1'b0, cap_q};
  end

  logic [STEP_W-1:0] count_step;
  assign count_step = dir_q ? count_q + 1'b1 : count_q - 1'b1;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      kp_q     <= 24'd838861;
      ki_q     <= 24'd8796;
      kd_q     <= 24'd160000;
      ilim_q   <= 24'd9830400;
      window_q <= 26'd327680;
      near_q   <= 26'd1966080;
      far_q    <= 26'd3276800;
      cap_q    <= 8'd10;
      count_q  <= '0;
      fused_q  <= '0;
      goal_q   <= '0;
      prev_q   <= '0;
      isum_q   <= '0;
      level_q  <= 1'b0;
      dir_q    <= 1'b0;
      fl_q     <= '{step_ok: 1'b0, us_ok: 1'b1, move: 1'b0, calib: 1'b0, enable: 1'b0};
      period_q <= 8'd255;
      m_axis_tvalid <= 1'b0;
    end else begin
      prod_q <= prod_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_KP:     kp_q     <= cfg_data_i[GAIN_W-1:0];
          REG_KI:     ki_q     <= cfg_data_i[GAIN_W-1:0];
          REG_KD:     kd_q     <= cfg_data_i[GAIN_W-1:0];
          REG_ILIM:   ilim_q   <= cfg_data_i[GAIN_W-1:0];
          REG_WINDOW: window_q <= cfg_data_i;
          REG_NEAR:   near_q   <= cfg_data_i;
          REG_FAR:    far_q    <= cfg_data_i;
          REG_CAP:    cap_q    <= cfg_data_i[7:0];
        endcase
      end

      // The final state loads the output register itself.
      if (m_axis_tvalid && m_axis_tready && state_q != ST_DONE) m_axis_tvalid <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q     <= s_axis_tuser;
            echo_a_q <= s_axis_tdata[15:0];
            echo_b_q <= s_axis_tdata[31:16];
            target_q <= s_axis_tdata[55:32];
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_DONE;
          priority case (op_q)
            OP_STEP: begin
              if (fl_q.enable) begin
                level_q <= !level_q;
                if (!level_q) begin
                  count_q <= count_step;
                  if (fl_q.step_ok && !fl_q.calib && goal_q == $signed(count_step))
                    fl_q.enable <= 1'b0;
                end
              end
            end
            OP_TICK: state_q <= ST_EA;
            OP_START: begin
              fl_q.us_ok   <= 1'b1;
              fl_q.step_ok <= 1'b0;
              fl_q.calib   <= 1'b1;
              fl_q.move    <= 1'b1;
              goal_q       <= '0;
            end
            OP_STOP: fl_q.move <= 1'b0;
            OP_HOME: begin
              if (fl_q.move && fl_q.calib) begin
                fl_q.step_ok <= 1'b1;
                fl_q.us_ok   <= 1'b0;
                fl_q.calib   <= 1'b0;
                fl_q.enable  <= 1'b0;
                count_q      <= '0;
                goal_q       <= target_q;
              end
            end
            default: ;
          endcase
        end
        ST_EA: state_q <= ST_EB;
        ST_EB: begin
          acc_q   <= ACC_W'(prod_q);
          state_q <= ST_CNT;
        end
        ST_CNT: begin
          us_q    <= US_W'((PR_W'(acc_q) + prod_q + ECHO_OFS) >>> 1);
          state_q <= ST_MS1;
        end
        ST_MS1: begin
          smm_q   <= prod_q[SMM_W-1:0] + MM_ORIGIN;
          state_q <= ST_MS2;
        end
        ST_MS2: begin
          ms_us_q <= prod_q[32 +: POS_W];
          state_q <= ST_FUSE;
        end
        ST_FUSE: begin
          state_q <= ST_ERR;
          if (fl_q.step_ok && fl_q.us_ok) begin
            if (inwin) begin
              fused_q <= cnt_s;
            end else begin
              fused_q      <= ms_us_q;
              fl_q.step_ok <= 1'b0;
            end
          end else if (fl_q.step_ok) begin
            fused_q <= cnt_s;
            if (smm_x >= $signed(CMP_W'(far_q))) fl_q.us_ok <= 1'b1;
          end else if (fl_q.us_ok) begin
            if (us_x < $signed(CMP_W'(near_q))) begin
              fused_q      <= ms_us_q;
              count_q      <= STEP_W'(ms_near);
              fl_q.step_ok <= 1'b1;
              fl_q.us_ok   <= 1'b0;
            end else if (inwin) begin
              fused_q      <= cnt_s;
              fl_q.step_ok <= 1'b1;
              fl_q.us_ok   <= 1'b0;
            end else begin
              fused_q <= ms_us_q;
            end
          end
        end
        ST_ERR: begin
          e_q     <= reject ? prev_q : e0;
          d_q     <= reject ? '0 : d0;
          prev_q  <= reject ? prev_q : e0;
          state_q <= ST_P;
        end
        ST_P: state_q <= ST_D;
        ST_D: begin
          acc_q   <= ACC_W'(prod_q);
          state_q <= ST_I;
        end
        ST_I: begin
          acc_q   <= acc_q + ACC_W'(prod_q);
          state_q <= ST_INT;
        end
        ST_INT: begin
          isum_q  <= iclamp;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          s_q     <= SUM_W'(acc_q >>> 8) + SUM_W'(isum_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          period_q    <= per[7:0];
          dir_q       <= fl_q.calib ? 1'b0 : !e_q[POS_W-1];
          fl_q.enable <= (e_q != '0) && fl_q.move;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, fl_q.calib, fl_q.move, fl_q.step_ok, fused_q,
                              fl_q.enable, dir_q, period_q};
            state_q       <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/fppc_checker.sv =====
module fppc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // One request at a time: the input closes once a request is taken.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after a request was accepted");

  // A new result only appears while a request is being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared with no request in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind fused_position_pid_controller_core fppc_port_checker u_fppc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
